// ----- hw/rtl/jns_pkg.sv -----
// Shared types, character codes and widths for the JSON number scanner.
package jns_pkg;

    localparam int LINE_BITS   = 20;
    localparam int COLUMN_BITS = 16;

    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_LO_E    = 8'h65;
    localparam logic [7:0] CH_UP_E    = 8'h45;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    typedef enum logic [8:0] {
        PH_IDLE    = 9'b0_0000_0001,
        PH_MINUS   = 9'b0_0000_0010,
        PH_ZERO    = 9'b0_0000_0100,
        PH_INT     = 9'b0_0000_1000,
        PH_DOT     = 9'b0_0001_0000,
        PH_FRAC    = 9'b0_0010_0000,
        PH_EXP     = 9'b0_0100_0000,
        PH_EXPSIGN = 9'b0_1000_0000,
        PH_EXPDIG  = 9'b1_0000_0000
    } t_phase;

    typedef enum logic [2:0] {
        ST_PART      = 3'd0,
        ST_DONE      = 3'd1,
        ST_ERR_MINUS = 3'd2,
        ST_ERR_FRAC  = 3'd3,
        ST_ERR_EXP   = 3'd4,
        ST_NONE      = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_input;
        logic       start_req;
    } t_in_item;

    typedef struct packed {
        t_status                status;
        logic                   keep_char;
        logic [7:0]             text_char;
        logic [LINE_BITS-1:0]   token_line;
        logic [COLUMN_BITS-1:0] token_column;
    } t_out_item;

    // grammar decision for one character
    typedef struct packed {
        t_status status;
        logic    keep;
        logic    took;
    } t_step;

    // coordinate update control
    typedef struct packed {
        logic took;
        logic capture;
    } t_scan_ctl;

endpackage

// ----- hw/rtl/json_number_scanner.sv -----
// Top level of the JSON number scanner: input register, grammar, counters, result register.
// Path: an input passes through the input register, then the result register, with one
//   combinational decision in between; the move into the result register waits on stall.
// Throughput: one character per cycle, held back only by stall on the result side.
// Reset (synchronous, active low): phase idle, line 1, column 0, start line 1,
//   start column 0, both pipeline registers empty.
module json_number_scanner (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  jns_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output jns_pkg::t_out_item o_result
);
    import jns_pkg::*;

    // input register
    logic       r_in_valid;
    t_in_item   r_in_item;
    // result register
    logic       r_out_valid;
    t_out_item  r_out_item;

    logic       out_free;   // result register can take a new value this cycle
    logic       advance;    // input register item is decided and moved on
    logic       in_xfer;    // input transfer at this edge
    t_step      step;
    t_scan_ctl  ctl;
    logic [LINE_BITS-1:0]   token_line;
    logic [COLUMN_BITS-1:0] token_column;
    t_out_item  n_out_item;

    // Flow control: the result register frees when empty or when its transfer
    // completes; the input register moves into it whenever it is free, so a
    // new character can enter every cycle while the downstream keeps up.
    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_xfer  = i_valid && !o_stall;

    jns_grammar u_grammar (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_item),
        .o_step    (step)
    );

    // consumed characters move the counters; capture only on a start request
    assign ctl = '{took: step.took, capture: r_in_item.start_req};

    jns_coord u_coord (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (advance),
        .i_character    (r_in_item.character),
        .i_ctl          (ctl),
        .o_token_line   (token_line),
        .o_token_column (token_column)
    );

    always_comb begin
        n_out_item.status       = step.status;
        n_out_item.keep_char    = step.keep;
        n_out_item.text_char    = 8'h00;
        if (step.keep) begin
            // exponent marker is normalized to lower case
            n_out_item.text_char = (r_in_item.character == CH_UP_E) ? CH_LO_E
                                                                     : r_in_item.character;
        end
        n_out_item.token_line   = token_line;
        n_out_item.token_column = token_column;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers carry no reset
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_item <= i_item;
        end
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out_item;

endmodule

// ----- hw/rtl/jns_grammar.sv -----
// Number grammar state machine: phase register and per-character decision.
module jns_grammar (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  jns_pkg::t_in_item i_item,
    output jns_pkg::t_step    o_step
);
    import jns_pkg::*;

    t_phase r_phase;
    t_phase n_phase;
    t_phase ph;
    logic   digit;
    logic   is_e;
    logic [7:0] c;

    always_comb begin
        c       = i_item.character;
        digit   = (c >= CH_ZERO) && (c <= CH_NINE);
        is_e    = (c == CH_LO_E) || (c == CH_UP_E);
        ph      = i_item.start_req ? PH_IDLE : r_phase;
        n_phase = PH_IDLE;
        o_step  = '{status: ST_PART, keep: 1'b0, took: 1'b0};

        if (i_item.end_of_input) begin
            unique case (ph) inside
                PH_MINUS:                               o_step.status = ST_ERR_MINUS;
                PH_DOT:                                 o_step.status = ST_ERR_FRAC;
                PH_EXP, PH_EXPSIGN:                     o_step.status = ST_ERR_EXP;
                PH_ZERO, PH_INT, PH_FRAC, PH_EXPDIG:    o_step.status = ST_DONE;
                default:                                o_step.status = ST_NONE;
            endcase
        end else begin
            unique case (ph)
                PH_MINUS: begin
                    if (c == CH_ZERO) begin
                        n_phase = PH_ZERO;  o_step.keep = 1'b1;
                    end else if (digit) begin
                        n_phase = PH_INT;   o_step.keep = 1'b1;
                    end else begin
                        o_step.status = ST_ERR_MINUS; o_step.took = 1'b1;
                    end
                end
                PH_ZERO, PH_INT: begin
                    if ((ph == PH_INT) && digit) begin
                        n_phase = PH_INT;   o_step.keep = 1'b1;
                    end else if (c == CH_DOT) begin
                        n_phase = PH_DOT;   o_step.keep = 1'b1;
                    end else if (is_e) begin
                        n_phase = PH_EXP;   o_step.keep = 1'b1;
                    end else begin
                        o_step.status = ST_DONE;
                    end
                end
                PH_DOT: begin
                    if (digit) begin
                        n_phase = PH_FRAC;  o_step.keep = 1'b1;
                    end else begin
                        o_step.status = ST_ERR_FRAC; o_step.took = 1'b1;
                    end
                end
                PH_FRAC: begin
                    if (digit) begin
                        n_phase = PH_FRAC;  o_step.keep = 1'b1;
                    end else if (is_e) begin
                        n_phase = PH_EXP;   o_step.keep = 1'b1;
                    end else begin
                        o_step.status = ST_DONE;
                    end
                end
                PH_EXP: begin
                    if ((c == CH_PLUS) || (c == CH_MINUS)) begin
                        n_phase = PH_EXPSIGN; o_step.keep = 1'b1;
                    end else if (digit) begin
                        n_phase = PH_EXPDIG;  o_step.keep = 1'b1;
                    end else begin
                        o_step.status = ST_ERR_EXP; o_step.took = 1'b1;
                    end
                end
                PH_EXPSIGN: begin
                    if (digit) begin
                        n_phase = PH_EXPDIG; o_step.keep = 1'b1;
                    end else begin
                        o_step.status = ST_ERR_EXP; o_step.took = 1'b1;
                    end
                end
                PH_EXPDIG: begin
                    if (digit) begin
                        n_phase = PH_EXPDIG; o_step.keep = 1'b1;
                    end else begin
                        o_step.status = ST_DONE;
                    end
                end
                default: begin
                    // idle, and any corrupted phase code
                    if (c == CH_MINUS) begin
                        n_phase = PH_MINUS; o_step.keep = 1'b1;
                    end else if (c == CH_ZERO) begin
                        n_phase = PH_ZERO;  o_step.keep = 1'b1;
                    end else if (digit) begin
                        n_phase = PH_INT;   o_step.keep = 1'b1;
                    end else begin
                        o_step.status = ST_NONE;
                    end
                end
            endcase
        end

        if (o_step.keep) begin
            o_step.took = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (i_advance) begin
            r_phase <= n_phase;
        end
    end

endmodule

// ----- hw/rtl/jns_coord.sv -----
// Line/column counters and token start capture.
module jns_coord (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_advance,
    input  logic [7:0]                      i_character,
    input  jns_pkg::t_scan_ctl              i_ctl,
    output logic [jns_pkg::LINE_BITS-1:0]   o_token_line,
    output logic [jns_pkg::COLUMN_BITS-1:0] o_token_column
);
    import jns_pkg::*;

    logic [LINE_BITS-1:0]   r_line,       n_line;
    logic [COLUMN_BITS-1:0] r_col,        n_col;
    logic [LINE_BITS-1:0]   r_start_line, n_start_line;
    logic [COLUMN_BITS-1:0] r_start_col,  n_start_col;

    always_comb begin
        n_line = r_line;
        n_col  = r_col;
        if (i_ctl.took) begin
            if (i_character == CH_NEWLINE) begin
                if (r_line != '1) begin
                    n_line = r_line + LINE_BITS'(1);
                end
                n_col = '0;
            end else if (r_col != '1) begin
                n_col = r_col + COLUMN_BITS'(1);
            end
        end
        n_start_line = r_start_line;
        n_start_col  = r_start_col;
        if (i_ctl.took && i_ctl.capture) begin
            n_start_line = n_line;
            n_start_col  = n_col;
        end
    end

    // result shows the start coordinates as they stand after this character
    assign o_token_line   = n_start_line;
    assign o_token_column = n_start_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line       <= LINE_BITS'(1);
            r_col        <= '0;
            r_start_line <= LINE_BITS'(1);
            r_start_col  <= '0;
        end else if (i_advance) begin
            r_line       <= n_line;
            r_col        <= n_col;
            r_start_line <= n_start_line;
            r_start_col  <= n_start_col;
        end
    end

endmodule
